// ===== src/bdasc_pkg.sv =====
// ----------------------------------------------------------------------------
// bdasc_pkg: shared types and constants for the decimal ASCII converter
// Holds the sequencer state type and the fixed field constants.
// ----------------------------------------------------------------------------
package bdasc_pkg;

   // Width of the value field on the request channel.
   localparam int VALUE_FIELD_W = 32;

   // Width of the digit character field on the response channel.
   localparam int CHAR_W = 6;

   // ASCII code of the character '0', in the width of the character field.
   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

   // Largest decimal digit value.
   localparam logic [3:0] DIGIT_MAX = 4'd9;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

endpackage

// ===== src/binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: unsigned binary to decimal ASCII characters
// Converts one unsigned number into a run of ASCII digits, most significant
// first, without leading zeros, using a shift-and-add-three sequencer.
// ----------------------------------------------------------------------------
// How to use this block:
// A number is handed over on the req_ channel; one transfer moves one value.
// The block then emits its decimal digits as ASCII characters on the rsp_
// channel, one transfer per character, most significant digit first. Leading
// zeros are dropped, and a value of zero gives the single character '0'.
// rsp_tlast is high on the final character of each run.
// Sequence: after the request transfer the block runs the shift-and-add-three
// loop over all VALUE_WIDTH bits, one bit a cycle through the shared digit
// correction unit, then drops the leading zero digits one by one, moves to
// emission, and sends one character per cycle while the receiver is ready.
// NDIG is the digit count of the widest value, 10 at the default width of 32 bits.
// The block accepts a new value only when idle, so req_tready is low from the
// request transfer until the last character has been transferred.
// When the receiver stalls, the current character and its last mark hold on
// rsp_tdata and rsp_tlast until they are taken. A synchronous reset returns
// the sequencer to idle and drops any conversion in progress.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [5:0] digit_char, [7:6] zero
   output logic        rsp_tlast    // last
);

   // Decimal digits needed for the widest value: floor(W * log10(2)) + 1,
   // with log10(2) approximated as 1233 / 4096.
   localparam int NDIG   = ((VALUE_WIDTH * 1233) / 4096) + 1;
   localparam int BCD_W  = 4 * NDIG;
   localparam int STEP_W = $clog2(VALUE_WIDTH + 1);
   localparam int CNT_W  = $clog2(NDIG + 1);

   bdasc_pkg::state_type state_ff, state_in;
   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [BCD_W-1:0]       bcd_adj;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] value_masked;
   logic [3:0]             top_digit;

   // Only the low VALUE_WIDTH bits of the value take part; a width beyond the
   // field gets zeros above it.
   if (VALUE_WIDTH <= bdasc_pkg::VALUE_FIELD_W) begin : g_narrow
      assign value_masked = req_tdata[VALUE_WIDTH-1:0];
   end else begin : g_wide
      assign value_masked = {{(VALUE_WIDTH - bdasc_pkg::VALUE_FIELD_W){1'b0}}, req_tdata};
   end

   // Shared correction unit: every BCD digit of five or more gets three added
   // before the next left shift, so that the shift carries into the next digit.
   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // The digit to be sent or tested is always the top one of the BCD word.
   assign top_digit = bcd_ff[BCD_W-1 -: 4];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdasc_pkg::ST_IDLE;
         step_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   always_comb begin
      state_in = state_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      step_in  = step_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         bdasc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               bin_in   = value_masked;
               bcd_in   = '0;
               step_in  = STEP_W'(VALUE_WIDTH);
               state_in = bdasc_pkg::ST_CONVERT;
            end
         end
         bdasc_pkg::ST_CONVERT: begin
            // One binary bit moves into the corrected BCD word each cycle.
            {bcd_in, bin_in} = {bcd_adj[BCD_W-2:0], bin_ff, 1'b0};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               cnt_in   = CNT_W'(NDIG);
               state_in = bdasc_pkg::ST_SKIP;
            end
         end
         bdasc_pkg::ST_SKIP: begin
            // Drop leading zero digits, but always keep the final one.
            if (top_digit == 4'd0 && cnt_ff != CNT_W'(1)) begin
               bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
               cnt_in = cnt_ff - CNT_W'(1);
            end else begin
               state_in = bdasc_pkg::ST_EMIT;
            end
         end
         bdasc_pkg::ST_EMIT: begin
            if (rsp_tready) begin
               bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
               cnt_in = cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = bdasc_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = bdasc_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == bdasc_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == bdasc_pkg::ST_EMIT);
   assign rsp_tdata  = {2'b00, bdasc_pkg::ASCII_ZERO + {2'b00, top_digit}};
   assign rsp_tlast  = (cnt_ff == CNT_W'(1));

endmodule

// ===== src/bdasc_checker.sv =====
// ----------------------------------------------------------------------------
// bdasc_checker: port-level checks for the decimal ASCII converter
// Watches the request and response channels and flags illegal behavior.
// ----------------------------------------------------------------------------
module bdasc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // Every character sent is a decimal digit in ASCII.
   a_digit_char : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:6] == 2'b00) &&
                     (rsp_tdata[5:0] >= bdasc_pkg::ASCII_ZERO) &&
                     (rsp_tdata[5:0] <= bdasc_pkg::ASCII_ZERO + {2'b00, bdasc_pkg::DIGIT_MAX}))
      else $error("response character is not a decimal digit");

   // A conversion runs the shift-and-add-three loop first, so no character follows a request at once.
   a_no_instant_rsp : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !rsp_tvalid)
      else $error("character offered right after the request transfer");

   // One value at a time: no new request while characters are being sent.
   a_one_at_a_time : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request accepted while a run is in progress");

   // A stalled character holds with its last mark.
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

endmodule

bind binary_to_decimal_ascii bdasc_checker u_bdasc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
